// ----- rtl/lph_pkg.sv -----
// Shared types and constants of the linear-probe hash table.
`default_nettype none
package lph_pkg;

   localparam logic [31:0] HASH_MUL   = 32'h045d_9f3b;
   localparam int          HASH_SHIFT = 16;
   localparam logic [31:0] VACANT_KEY = 32'd0;

   typedef enum logic [1:0] {
      MODE_LOOKUP = 2'd0,
      MODE_INSERT = 2'd1,
      MODE_DELETE = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      KIND_HIT  = 2'd0,
      KIND_DONE = 2'd1,
      KIND_MISS = 2'd2,
      KIND_FULL = 2'd3
   } kind_type;

   typedef struct packed {
      logic     latch_req;
      logic     hash_cand;
      logic     hash1;
      logic     hash2;
      logic     mod_start;
      logic     load_home;
      logic     mem_rd;
      logic     mark;
      logic     step;
      logic     start_del;
      logic     move;
      logic     free;
      logic     ins_wr;
      logic     upd_wr;
      logic     full;
      logic     clr_wr;
      logic     rsp_load;
      kind_type rsp_kind;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     mod_done;
      logic     rd_valid;
      logic     rd_match;
      logic     n_full;
      logic     n_last;
      logic     do_move;
      logic     p_last;
      logic     rsp_free;
   } sts_type;

endpackage
`default_nettype wire

// ----- rtl/lph_dp.sv -----
// Datapath: hash, remainder unit, slot memory, probe pointers and result register.
`default_nettype none
module lph_dp
   import lph_pkg::*;
#(
   parameter int TABLE_SLOTS = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output sts_type          sts,
   input  wire logic [1:0]  req_mode,
   input  wire logic [31:0] req_key,
   input  wire logic [31:0] req_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_payload,
   output logic [7:0]       rsp_slot,
   output logic [31:0]      rsp_conflict_total
);

   localparam int IW   = $clog2(TABLE_SLOTS);
   localparam bit POW2 = ((1 << IW) == TABLE_SLOTS);
   localparam logic [IW:0]   N_FULL = (IW+1)'(TABLE_SLOTS);
   localparam logic [IW:0]   N_LAST = (IW+1)'(TABLE_SLOTS - 1);
   localparam logic [IW-1:0] P_LAST = IW'(TABLE_SLOTS - 1);
   localparam logic [31:0]   SLOTS_W = 32'(TABLE_SLOTS);
   localparam logic [31:0]   RECIP   = 32'((64'd1 << 32) / TABLE_SLOTS);

   logic            mem_valid [TABLE_SLOTS];
   logic [31:0]     mem_key   [TABLE_SLOTS];
   logic [31:0]     mem_pay   [TABLE_SLOTS];

   mode_type        mode_ff;
   logic [31:0]     key_ff, value_ff;
   logic [31:0]     x1_ff, x2_ff;
   logic [IW-1:0]   rem_ff;
   logic [31:0]     dvd_ff;
   logic [63:0]     prod_ff;
   logic [31:0]     part_ff;
   logic [1:0]      cnt_ff;
   logic            busy_ff;
   logic [IW-1:0]   p_ff, hole_ff, found_ff;
   logic [IW:0]     n_ff;
   logic            rd_valid_ff;
   logic [31:0]     rd_key_ff, rd_pay_ff;
   logic [31:0]     conflict_ff;
   logic            rsp_valid_ff;
   logic [1:0]      rsp_status_ff;
   logic [31:0]     rsp_payload_ff;
   logic [7:0]      rsp_slot_ff;
   logic [31:0]     rsp_conflict_ff;

   logic [31:0]     hash_src, hash_fin;
   logic [IW-1:0]   p_next;
   logic [31:0]     qn;
   logic            wr_en, wr_valid;
   logic [IW-1:0]   wr_addr;
   logic [31:0]     wr_key, wr_pay;

   assign hash_src = cmd.hash_cand ? rd_key_ff : key_ff;
   assign hash_fin = (x2_ff >> HASH_SHIFT) ^ x2_ff;
   assign p_next   = (p_ff == P_LAST) ? '0 : p_ff + 1'b1;
   assign qn       = prod_ff[63:32] * SLOTS_W;

   always_comb begin
      wr_en    = 1'b0;
      wr_valid = 1'b1;
      wr_addr  = p_ff;
      wr_key   = key_ff;
      wr_pay   = value_ff;
      if (cmd.clr_wr) begin
         wr_en    = 1'b1;
         wr_valid = 1'b0;
         wr_key   = VACANT_KEY;
         wr_pay   = '0;
      end else if (cmd.ins_wr || cmd.upd_wr) begin
         wr_en = 1'b1;
      end else if (cmd.move) begin
         wr_en   = 1'b1;
         wr_addr = hole_ff;
         wr_key  = rd_key_ff;
         wr_pay  = rd_pay_ff;
      end else if (cmd.free) begin
         wr_en    = 1'b1;
         wr_valid = 1'b0;
         wr_addr  = hole_ff;
         wr_key   = VACANT_KEY;
         wr_pay   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_valid[wr_addr] <= wr_valid;
         mem_key[wr_addr]   <= wr_key;
         mem_pay[wr_addr]   <= wr_pay;
      end
      if (cmd.mem_rd) begin
         rd_valid_ff <= mem_valid[p_ff];
         rd_key_ff   <= mem_key[p_ff];
         rd_pay_ff   <= mem_pay[p_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         mode_ff  <= mode_type'(req_mode);
         key_ff   <= req_key;
         value_ff <= req_value;
      end
      if (cmd.hash1) begin
         x1_ff <= ((hash_src >> HASH_SHIFT) ^ hash_src) * HASH_MUL;
      end
      if (cmd.hash2) begin
         x2_ff <= ((x1_ff >> HASH_SHIFT) ^ x1_ff) * HASH_MUL;
      end
      if (cmd.mark) begin
         found_ff <= p_ff;
      end
      if (cmd.load_home) begin
         n_ff <= '0;
      end else if (cmd.start_del) begin
         n_ff <= '0;
      end else if (cmd.step) begin
         n_ff <= n_ff + 1'b1;
      end
      if (cmd.start_del) begin
         hole_ff <= p_ff;
      end else if (cmd.move) begin
         hole_ff <= p_ff;
      end
      if (cmd.rsp_load) begin
         rsp_conflict_ff <= conflict_ff;
         case (cmd.rsp_kind)
            KIND_HIT: begin
               rsp_status_ff  <= ST_OK;
               rsp_payload_ff <= rd_pay_ff;
               rsp_slot_ff    <= 8'(found_ff);
            end
            KIND_DONE: begin
               rsp_status_ff  <= ST_OK;
               rsp_payload_ff <= '0;
               rsp_slot_ff    <= 8'(found_ff);
            end
            KIND_FULL: begin
               rsp_status_ff  <= ST_FULL;
               rsp_payload_ff <= '0;
               rsp_slot_ff    <= '0;
            end
            default: begin
               rsp_status_ff  <= ST_MISS;
               rsp_payload_ff <= '0;
               rsp_slot_ff    <= '0;
            end
         endcase
      end
   end

   // If TABLE_SLOTS is not a power of two, the remainder uses a reciprocal
   // estimate low by at most one quotient, so a single compare and subtract finishes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         p_ff         <= '0;
         conflict_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.mod_start) begin
            if (POW2) begin
               rem_ff <= hash_fin[IW-1:0];
            end else begin
               dvd_ff  <= hash_fin;
               cnt_ff  <= '0;
               busy_ff <= 1'b1;
            end
         end else if (busy_ff) begin
            case (cnt_ff)
               2'd0: begin
                  prod_ff <= {32'd0, dvd_ff} * {32'd0, RECIP};
               end
               2'd1: begin
                  part_ff <= dvd_ff - qn;
               end
               default: begin
                  rem_ff  <= (part_ff >= SLOTS_W) ? IW'(part_ff - SLOTS_W) : IW'(part_ff);
                  busy_ff <= 1'b0;
               end
            endcase
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (cmd.load_home) begin
            p_ff <= rem_ff;
         end else if (cmd.start_del || cmd.step || cmd.clr_wr) begin
            p_ff <= p_next;
         end
         if (cmd.ins_wr) begin
            conflict_ff <= conflict_ff + 32'(n_ff);
         end else if (cmd.full) begin
            conflict_ff <= conflict_ff + 32'(TABLE_SLOTS);
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      sts.mode     = mode_ff;
      sts.mod_done = !busy_ff;
      sts.rd_valid = rd_valid_ff;
      sts.rd_match = (rd_key_ff == key_ff);
      sts.n_full   = (n_ff == N_FULL);
      sts.n_last   = (n_ff == N_LAST);
      sts.p_last   = (p_ff == P_LAST);
      sts.rsp_free = !rsp_valid_ff || !rsp_stall;
      if (p_ff > hole_ff) begin
         sts.do_move = (rem_ff <= hole_ff) || (rem_ff > p_ff);
      end else begin
         sts.do_move = (rem_ff <= hole_ff) && (rem_ff > p_ff);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_payload        = rsp_payload_ff;
   assign rsp_slot           = rsp_slot_ff;
   assign rsp_conflict_total = rsp_conflict_ff;

endmodule
`default_nettype wire

// ----- rtl/lph_ctrl.sv -----
// Controller: sequences clearing, hashing, probing, insertion, compaction and the result.
`default_nettype none
module lph_ctrl
   import lph_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   output cmd_type      cmd,
   input  wire sts_type sts
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_HASH1, S_HASH2, S_MODS, S_MODW, S_FREAD, S_FCHK,
      S_DREAD, S_DCHK, S_DH1, S_DH2, S_DMODS, S_DMODW, S_DMOVE, S_DFIN
   } state_type;

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;
   logic      resp_ff, resp_in;

   assign req_stall = (state_ff != S_IDLE) || resp_ff;

   always_comb begin
      cmd          = '0;
      cmd.rsp_kind = kind_ff;
      state_in     = state_ff;
      kind_in      = kind_ff;
      resp_in      = resp_ff;
      if (resp_ff) begin
         if (sts.rsp_free) begin
            cmd.rsp_load = 1'b1;
            resp_in      = 1'b0;
         end
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               cmd.clr_wr = 1'b1;
               if (sts.p_last) begin
                  state_in = S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  cmd.latch_req = 1'b1;
                  state_in      = S_HASH1;
               end
            end
            S_HASH1: begin
               if (sts.mode == MODE_NONE) begin
                  kind_in  = KIND_MISS;
                  resp_in  = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  cmd.hash1 = 1'b1;
                  state_in  = S_HASH2;
               end
            end
            S_HASH2: begin
               cmd.hash2 = 1'b1;
               state_in  = S_MODS;
            end
            S_MODS: begin
               cmd.mod_start = 1'b1;
               state_in      = S_MODW;
            end
            S_MODW: begin
               if (sts.mod_done) begin
                  cmd.load_home = 1'b1;
                  state_in      = S_FREAD;
               end
            end
            S_FREAD: begin
               if (sts.n_full) begin
                  if (sts.mode == MODE_INSERT) begin
                     cmd.full = 1'b1;
                     kind_in  = KIND_FULL;
                  end else begin
                     kind_in = KIND_MISS;
                  end
                  resp_in  = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  cmd.mem_rd = 1'b1;
                  state_in   = S_FCHK;
               end
            end
            S_FCHK: begin
               cmd.mark = 1'b1;
               if (!sts.rd_valid) begin
                  if (sts.mode == MODE_INSERT) begin
                     cmd.ins_wr = 1'b1;
                     kind_in    = KIND_DONE;
                  end else begin
                     kind_in = KIND_MISS;
                  end
                  resp_in  = 1'b1;
                  state_in = S_IDLE;
               end else if (sts.rd_match) begin
                  if (sts.mode == MODE_DELETE) begin
                     cmd.start_del = 1'b1;
                     kind_in       = KIND_DONE;
                     state_in      = S_DREAD;
                  end else begin
                     cmd.upd_wr = (sts.mode == MODE_INSERT);
                     kind_in    = (sts.mode == MODE_INSERT) ? KIND_DONE : KIND_HIT;
                     resp_in    = 1'b1;
                     state_in   = S_IDLE;
                  end
               end else begin
                  cmd.step = 1'b1;
                  state_in = S_FREAD;
               end
            end
            S_DREAD: begin
               if (sts.n_last) begin
                  state_in = S_DFIN;
               end else begin
                  cmd.mem_rd = 1'b1;
                  state_in   = S_DCHK;
               end
            end
            S_DCHK: begin
               state_in = sts.rd_valid ? S_DH1 : S_DFIN;
            end
            S_DH1: begin
               cmd.hash_cand = 1'b1;
               cmd.hash1     = 1'b1;
               state_in      = S_DH2;
            end
            S_DH2: begin
               cmd.hash2 = 1'b1;
               state_in  = S_DMODS;
            end
            S_DMODS: begin
               cmd.mod_start = 1'b1;
               state_in      = S_DMODW;
            end
            S_DMODW: begin
               if (sts.mod_done) begin
                  state_in = S_DMOVE;
               end
            end
            S_DMOVE: begin
               cmd.move = sts.do_move;
               cmd.step = 1'b1;
               state_in = S_DREAD;
            end
            S_DFIN: begin
               cmd.free = 1'b1;
               resp_in  = 1'b1;
               state_in = S_IDLE;
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         kind_ff  <= KIND_MISS;
         resp_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
         resp_ff  <= resp_in;
      end
   end

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> sts.rsp_free) else $error("result loaded over a pending transfer");
   a_mod_once: assert property (@(posedge clock) disable iff (reset)
      cmd.mod_start |=> !cmd.mod_start) else $error("remainder unit restarted");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.latch_req |=> req_stall) else $error("second request taken while busy");
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.ins_wr, cmd.upd_wr, cmd.move, cmd.free, cmd.clr_wr}) <= 1)
      else $error("two slot writes in one cycle");

endmodule
`default_nettype wire

// ----- rtl/linear_probe_hash_table_core.sv -----
// Top level of the linear-probe hash table of 32-bit keys and payloads.
// Requests arrive on the req_ channel (mode, key, value) and each one
// gives exactly one result on the rsp_ channel (status, payload, slot,
// conflict_total). A transfer happens at a clock edge where valid is high
// and stall is low.
// One request is worked on at a time. A request is latched, hashed through
// the x1 and x2 registers and reduced to a home slot, through the extra
// remainder steps when TABLE_SLOTS is not a power of two; each slot probed
// is then read from the single-port slot memory and checked, and the
// result register is loaded once it is free. A delete then reads each slot
// that follows the hole, rehashes its key and moves the entry into the hole
// where its home slot allows, until an empty slot or the rest of the table
// ends the scan and the last hole is freed. The next request is taken once the result is loaded.
// After reset the block clears all valid bits in one pass over the slots and
// holds req_stall high meanwhile. A stalled result waits in the output
// register; the next request may be accepted during that wait.
`default_nettype none
module linear_probe_hash_table_core
   import lph_pkg::*;
#(
   parameter int TABLE_SLOTS = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_mode,
   input  wire logic [31:0] req_key,
   input  wire logic [31:0] req_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_payload,
   output logic [7:0]       rsp_slot,
   output logic [31:0]      rsp_conflict_total
);

   cmd_type cmd;
   sts_type sts;

   lph_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   lph_dp #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_mode           (req_mode),
      .req_key            (req_key),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_payload        (rsp_payload),
      .rsp_slot           (rsp_slot),
      .rsp_conflict_total (rsp_conflict_total)
   );

endmodule
`default_nettype wire
